// File: rtl/core/tca_pkg.sv
// Shared widths and defaults for the triangle circumcenter and area block.
// No dependencies; imported by triangle_circumcenter_area.
package tca_pkg;

   localparam int DEF_COORD_BITS = 16;
   localparam int DEF_FRAC_BITS  = 8;
   localparam int CENTER_BITS    = 32;
   localparam int AREA_BITS      = 33;
   localparam int DIV_STEPS      = 32;
   localparam int OUT_FIELD_BITS = 2 * CENTER_BITS + AREA_BITS;
   localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
   localparam int OUT_USER_BITS  = 2;

   localparam logic [CENTER_BITS-1:0] CENTER_MAX = {1'b0, {(CENTER_BITS-1){1'b1}}};
   localparam logic [CENTER_BITS-1:0] CENTER_MIN = {1'b1, {(CENTER_BITS-1){1'b0}}};

endpackage

// File: rtl/core/triangle_circumcenter_area.sv
// Throughput: one item per cycle while the output register is empty or being taken.
// Five arithmetic stages, a range-check stage and a 32-stage restoring divider set the depth.
// The whole pipe advances when the output register is empty or being taken.
// Reset (synchronous, active high) clears all valid bits; payload registers are not reset.
// Top level of the triangle circumcenter and doubled-area pipeline.
// Depends on tca_pkg.
module triangle_circumcenter_area #(
   parameter int COORD_BITS = tca_pkg::DEF_COORD_BITS,
   parameter int FRAC_BITS  = tca_pkg::DEF_FRAC_BITS,
   parameter int IN_BITS    = ((6 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
   input  logic [IN_BITS-1:0]                req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // center_x, center_y, area_twice
   output logic [tca_pkg::OUT_DATA_BITS-1:0] rsp_tdata,
   // is_collinear, center_saturated
   output logic [tca_pkg::OUT_USER_BITS-1:0] rsp_tuser
);
   import tca_pkg::*;

   localparam int W   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int DW  = W + 1;
   localparam int PW  = 2 * W + 2;
   localparam int EW  = 2 * W + 3;
   localparam int GW  = 2 * W + 4;
   localparam int NW  = 3 * W + 5;
   localparam int HW  = NW + F;
   localparam int MW  = HW + DIV_STEPS;
   localparam int VW  = W + F + 2;
   localparam int CW  = (VW > CENTER_BITS + 1) ? VW : CENTER_BITS + 1;
   localparam int LW  = (GW > AREA_BITS + 1) ? GW : AREA_BITS + 1;
   localparam int NST = 6 + DIV_STEPS;

   function automatic logic [GW+DIV_STEPS-1:0] div_step(input logic [GW-1:0] rem,
                                                        input logic [DIV_STEPS-1:0] lq,
                                                        input logic [GW-1:0] dv);
      logic [GW:0] t;
      logic [GW:0] dif;
      logic        ge;
      t   = {rem, lq[DIV_STEPS-1]};
      dif = t - {1'b0, dv};
      ge  = (t >= {1'b0, dv});
      return {(ge ? dif[GW-1:0] : t[GW-1:0]), lq[DIV_STEPS-2:0], ge};
   endfunction

   function automatic logic [CENTER_BITS:0] clamp_box(input logic signed [VW-1:0] v);
      logic signed [CW-1:0] ext;
      logic                 ovf;
      ext = CW'(v);
      ovf = !(&ext[CW-1:CENTER_BITS-1]) && (|ext[CW-1:CENTER_BITS-1]);
      if (ovf) begin
         return {1'b1, (ext[CW-1] ? CENTER_MIN : CENTER_MAX)};
      end
      return {1'b0, ext[CENTER_BITS-1:0]};
   endfunction

   function automatic logic signed [VW-1:0] box_mid(input logic signed [W-1:0] p,
                                                    input logic signed [W-1:0] q,
                                                    input logic signed [W-1:0] r);
      logic signed [W-1:0] lo;
      logic signed [W-1:0] hi;
      logic [VW-1:0]       span;
      lo = p;
      hi = p;
      if (q < lo) lo = q;
      if (r < lo) lo = r;
      if (q > hi) hi = q;
      if (r > hi) hi = r;
      span = VW'(DW'(hi) - DW'(lo));
      span = (span << F) >> 1;
      return (VW'(lo) <<< F) + $signed(span);
   endfunction

   logic                adv;
   logic [NST-1:0]      vld_ff, vld_in;
   logic                out_vld_ff;
   logic [CENTER_BITS-1:0] out_cx_ff, out_cy_ff;
   logic [AREA_BITS-1:0]   out_area_ff;
   logic                out_col_ff, out_sat_ff;

   logic signed [W-1:0] ax, ay, bx, by, cx, cy;

   // stage 1
   logic signed [DW-1:0] a1_ff, b1_ff, c1_ff, d1_ff;
   logic signed [DW-1:0] sabx1_ff, saby1_ff, sacx1_ff, sacy1_ff, ucbx1_ff, ucby1_ff;
   logic signed [VW-1:0] vx1_ff, vy1_ff;
   // stage 2
   logic signed [DW-1:0] a2_ff, b2_ff, c2_ff, d2_ff;
   logic signed [PW-1:0] pe1_ff, pe2_ff, pf1_ff, pf2_ff, pg1_ff, pg2_ff;
   logic [CENTER_BITS:0] bx2_ff, by2_ff;
   // stage 3
   logic signed [DW-1:0] a3_ff, b3_ff, c3_ff, d3_ff;
   logic signed [EW-1:0] e3_ff, f3_ff;
   logic signed [GW-1:0] g3_ff;
   logic [CENTER_BITS:0] bx3_ff, by3_ff;
   // stage 4
   logic signed [NW-2:0] de4_ff, bf4_ff, af4_ff, ce4_ff;
   logic signed [GW-1:0] g4_ff;
   logic [CENTER_BITS:0] bx4_ff, by4_ff;
   // stage 5
   logic [MW-1:0]        mx5_ff, my5_ff;
   logic [GW-1:0]        dv5_ff;
   logic                 nx5_ff, ny5_ff, col5_ff;
   logic [AREA_BITS-1:0] area5_ff;
   logic [CENTER_BITS:0] bx5_ff, by5_ff;
   logic signed [NW-1:0] numx_in, numy_in;
   logic [NW-1:0]        magx_in, magy_in;
   logic [GW-1:0]        gmag_in;
   logic [LW-1:0]        afull_in;

   // divider stages, index 0 is the range-check stage
   logic [GW-1:0]          remx_ff [0:DIV_STEPS];
   logic [GW-1:0]          remy_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0]   lqx_ff  [0:DIV_STEPS];
   logic [DIV_STEPS-1:0]   lqy_ff  [0:DIV_STEPS];
   logic [GW-1:0]          dv_ff   [0:DIV_STEPS];
   logic [3:0]             flg_ff  [0:DIV_STEPS];
   logic                   col_ff  [0:DIV_STEPS];
   logic [AREA_BITS-1:0]   area_ff [0:DIV_STEPS];
   logic [CENTER_BITS:0]   boxx_ff [0:DIV_STEPS];
   logic [CENTER_BITS:0]   boxy_ff [0:DIV_STEPS];

   logic [CENTER_BITS-1:0] qx, qy, cx_in, cy_in;
   logic                   satx_in, saty_in;

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   assign ax = req_tdata[0*W +: W];
   assign ay = req_tdata[1*W +: W];
   assign bx = req_tdata[2*W +: W];
   assign by = req_tdata[3*W +: W];
   assign cx = req_tdata[4*W +: W];
   assign cy = req_tdata[5*W +: W];

   assign vld_in = {vld_ff[NST-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff    <= DW'(bx) - DW'(ax);
         b1_ff    <= DW'(by) - DW'(ay);
         c1_ff    <= DW'(cx) - DW'(ax);
         d1_ff    <= DW'(cy) - DW'(ay);
         sabx1_ff <= DW'(ax) + DW'(bx);
         saby1_ff <= DW'(ay) + DW'(by);
         sacx1_ff <= DW'(ax) + DW'(cx);
         sacy1_ff <= DW'(ay) + DW'(cy);
         ucbx1_ff <= DW'(cx) - DW'(bx);
         ucby1_ff <= DW'(cy) - DW'(by);
         vx1_ff   <= box_mid(ax, bx, cx);
         vy1_ff   <= box_mid(ay, by, cy);

         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         c2_ff  <= c1_ff;
         d2_ff  <= d1_ff;
         pe1_ff <= PW'(a1_ff) * PW'(sabx1_ff);
         pe2_ff <= PW'(b1_ff) * PW'(saby1_ff);
         pf1_ff <= PW'(c1_ff) * PW'(sacx1_ff);
         pf2_ff <= PW'(d1_ff) * PW'(sacy1_ff);
         pg1_ff <= PW'(a1_ff) * PW'(ucby1_ff);
         pg2_ff <= PW'(b1_ff) * PW'(ucbx1_ff);
         bx2_ff <= clamp_box(vx1_ff);
         by2_ff <= clamp_box(vy1_ff);

         a3_ff  <= a2_ff;
         b3_ff  <= b2_ff;
         c3_ff  <= c2_ff;
         d3_ff  <= d2_ff;
         e3_ff  <= EW'(pe1_ff) + EW'(pe2_ff);
         f3_ff  <= EW'(pf1_ff) + EW'(pf2_ff);
         g3_ff  <= (GW'(pg1_ff) - GW'(pg2_ff)) <<< 1;
         bx3_ff <= bx2_ff;
         by3_ff <= by2_ff;

         de4_ff <= (NW-1)'(d3_ff) * (NW-1)'(e3_ff);
         bf4_ff <= (NW-1)'(b3_ff) * (NW-1)'(f3_ff);
         af4_ff <= (NW-1)'(a3_ff) * (NW-1)'(f3_ff);
         ce4_ff <= (NW-1)'(c3_ff) * (NW-1)'(e3_ff);
         g4_ff  <= g3_ff;
         bx4_ff <= bx3_ff;
         by4_ff <= by3_ff;
      end
   end

   always_comb begin
      numx_in  = NW'(de4_ff) - NW'(bf4_ff);
      numy_in  = NW'(af4_ff) - NW'(ce4_ff);
      magx_in  = numx_in[NW-1] ? NW'(-numx_in) : NW'(numx_in);
      magy_in  = numy_in[NW-1] ? NW'(-numy_in) : NW'(numy_in);
      gmag_in  = g4_ff[GW-1] ? GW'(-g4_ff) : GW'(g4_ff);
      afull_in = LW'(gmag_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx5_ff  <= MW'(magx_in) << F;
         my5_ff  <= MW'(magy_in) << F;
         dv5_ff  <= gmag_in;
         nx5_ff  <= numx_in[NW-1] ^ g4_ff[GW-1];
         ny5_ff  <= numy_in[NW-1] ^ g4_ff[GW-1];
         col5_ff <= (g4_ff == '0);
         area5_ff <= (|afull_in[LW-1:AREA_BITS]) ? {AREA_BITS{1'b1}}
                                                 : afull_in[AREA_BITS-1:0];
         bx5_ff  <= bx4_ff;
         by5_ff  <= by4_ff;

         remx_ff[0] <= mx5_ff[GW+DIV_STEPS-1:DIV_STEPS];
         remy_ff[0] <= my5_ff[GW+DIV_STEPS-1:DIV_STEPS];
         lqx_ff[0]  <= mx5_ff[DIV_STEPS-1:0];
         lqy_ff[0]  <= my5_ff[DIV_STEPS-1:0];
         dv_ff[0]   <= dv5_ff;
         flg_ff[0]  <= {ny5_ff, nx5_ff,
                        (my5_ff[MW-1:DIV_STEPS] >= HW'(dv5_ff)),
                        (mx5_ff[MW-1:DIV_STEPS] >= HW'(dv5_ff))};
         col_ff[0]  <= col5_ff;
         area_ff[0] <= area5_ff;
         boxx_ff[0] <= bx5_ff;
         boxy_ff[0] <= by5_ff;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) begin
            {remx_ff[k+1], lqx_ff[k+1]} <= div_step(remx_ff[k], lqx_ff[k], dv_ff[k]);
            {remy_ff[k+1], lqy_ff[k+1]} <= div_step(remy_ff[k], lqy_ff[k], dv_ff[k]);
            dv_ff[k+1]   <= dv_ff[k];
            flg_ff[k+1]  <= flg_ff[k];
            col_ff[k+1]  <= col_ff[k];
            area_ff[k+1] <= area_ff[k];
            boxx_ff[k+1] <= boxx_ff[k];
            boxy_ff[k+1] <= boxy_ff[k];
         end
      end
   end

   always_comb begin
      qx = lqx_ff[DIV_STEPS];
      qy = lqy_ff[DIV_STEPS];
      if (flg_ff[DIV_STEPS][2]) begin
         satx_in = flg_ff[DIV_STEPS][0] || (qx > CENTER_MIN);
         cx_in   = satx_in ? CENTER_MIN : CENTER_BITS'(0) - qx;
      end else begin
         satx_in = flg_ff[DIV_STEPS][0] || qx[CENTER_BITS-1];
         cx_in   = satx_in ? CENTER_MAX : qx;
      end
      if (flg_ff[DIV_STEPS][3]) begin
         saty_in = flg_ff[DIV_STEPS][1] || (qy > CENTER_MIN);
         cy_in   = saty_in ? CENTER_MIN : CENTER_BITS'(0) - qy;
      end else begin
         saty_in = flg_ff[DIV_STEPS][1] || qy[CENTER_BITS-1];
         cy_in   = saty_in ? CENTER_MAX : qy;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_col_ff  <= col_ff[DIV_STEPS];
         out_area_ff <= col_ff[DIV_STEPS] ? '0 : area_ff[DIV_STEPS];
         if (col_ff[DIV_STEPS]) begin
            out_cx_ff  <= boxx_ff[DIV_STEPS][CENTER_BITS-1:0];
            out_cy_ff  <= boxy_ff[DIV_STEPS][CENTER_BITS-1:0];
            out_sat_ff <= boxx_ff[DIV_STEPS][CENTER_BITS] || boxy_ff[DIV_STEPS][CENTER_BITS];
         end else begin
            out_cx_ff  <= cx_in;
            out_cy_ff  <= cy_in;
            out_sat_ff <= satx_in || saty_in;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}}, out_area_ff, out_cy_ff,
                        out_cx_ff};
   assign rsp_tuser  = {out_sat_ff, out_col_ff};

endmodule
